// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the RTL modules.
// Define NO_ASSERTIONS to compile them away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

// ----- hdl/e2q_pkg.sv -----
// Package for the Euler angle to quaternion block: widths, CORDIC table, types.
// Depends on nothing.
`default_nettype none
package e2q_pkg;
    localparam int CordicSteps = 16;
    localparam int AngW = 16;
    localparam int QW = 16;
    // CORDIC working width: Q30 values with margin; phase in 2^31 = pi units.
    localparam int XW = 33;
    localparam int ZW = 34;
    localparam logic signed [XW-1:0] CordicGain = 33'sd652032874;

    typedef logic signed [AngW-1:0] ang_t;
    typedef logic signed [QW-1:0] q15_t;
    // Rounded sine and cosine reach +1.0, which needs one bit above Q1.15.
    typedef logic signed [QW:0] trig_t;
    typedef logic signed [XW-1:0] cx_t;
    typedef logic signed [ZW-1:0] cz_t;

    typedef struct packed {
        ang_t heading_angle;
        ang_t bank_angle;
        ang_t pitch_angle;
    } angles_t;

    typedef struct packed {
        q15_t comp_first;
        q15_t comp_second;
        q15_t comp_third;
        q15_t comp_fourth;
    } quat_t;

    typedef struct packed {
        cx_t x;
        cx_t y;
        cz_t z;
    } rot_t;

    typedef struct packed {
        trig_t s;
        trig_t c;
    } sc_t;

    function automatic cz_t atan_phase(input int i);
        case (i)
            0: atan_phase = 34'sd536870912;
            1: atan_phase = 34'sd316933406;
            2: atan_phase = 34'sd167458907;
            3: atan_phase = 34'sd85004756;
            4: atan_phase = 34'sd42667331;
            5: atan_phase = 34'sd21354465;
            6: atan_phase = 34'sd10679838;
            7: atan_phase = 34'sd5340245;
            8: atan_phase = 34'sd2670163;
            9: atan_phase = 34'sd1335087;
            10: atan_phase = 34'sd667544;
            11: atan_phase = 34'sd333772;
            12: atan_phase = 34'sd166886;
            13: atan_phase = 34'sd83443;
            14: atan_phase = 34'sd41722;
            15: atan_phase = 34'sd20861;
            16: atan_phase = 34'sd10430;
            17: atan_phase = 34'sd5215;
            18: atan_phase = 34'sd2608;
            19: atan_phase = 34'sd1304;
            20: atan_phase = 34'sd652;
            21: atan_phase = 34'sd326;
            22: atan_phase = 34'sd163;
            default: atan_phase = 34'sd81;
        endcase
    endfunction

    // One CORDIC micro-rotation.
    function automatic rot_t cordic_step(input rot_t r, input int i);
        rot_t o;
        cx_t dx;
        cx_t dy;
        dx = r.y >>> i;
        dy = r.x >>> i;
        if (!r.z[ZW-1])
        begin
            o.x = r.x - dx;
            o.y = r.y + dy;
            o.z = r.z - atan_phase(i);
        end
        else
        begin
            o.x = r.x + dx;
            o.y = r.y - dy;
            o.z = r.z + atan_phase(i);
        end
        return o;
    endfunction

    // Round Q30 to Q15, floor((v + 2^14) / 2^15).
    function automatic trig_t round_q15(input cx_t v);
        cx_t t;
        t = (v + cx_t'(16384)) >>> 15;
        return t[QW:0];
    endfunction
endpackage
`default_nettype wire

// ----- hdl/e2q_if.sv -----
// Valid/ready channel interface carrying one payload word.
// Depends on nothing.
`default_nettype none
interface e2q_if #(parameter type payload_t = logic) (input wire logic clk);
    logic valid;
    logic ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hdl/e2q_cordic.sv -----
// Pipelined CORDIC for three half angles, one step per stage.
// Depends on e2q_pkg and assert_macros.svh.
`default_nettype none
module e2q_cordic (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic adv,
    input  wire logic in_valid,
    input  e2q_pkg::angles_t in_ang,
    output logic out_valid,
    output e2q_pkg::sc_t out_sc [3]
);
    import e2q_pkg::*;
    `include "assert_macros.svh"

    rot_t rot_reg [CordicSteps+1][3];
    logic [CordicSteps:0] vld_reg;
    sc_t sc_reg [3];
    logic sc_vld_reg;
    ang_t ang_in [3];

    assign ang_in[0] = in_ang.heading_angle;
    assign ang_in[1] = in_ang.bank_angle;
    assign ang_in[2] = in_ang.pitch_angle;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            sc_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[CordicSteps-1:0], in_valid};
            sc_vld_reg <= vld_reg[CordicSteps];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                rot_reg[0][k].x <= CordicGain;
                rot_reg[0][k].y <= '0;
                rot_reg[0][k].z <= {{(ZW-AngW-15){ang_in[k][AngW-1]}}, ang_in[k], 15'd0};
                for (int i = 0; i < CordicSteps; i++)
                    rot_reg[i+1][k] <= cordic_step(rot_reg[i][k], i);
                sc_reg[k].s <= round_q15(rot_reg[CordicSteps][k].y);
                sc_reg[k].c <= round_q15(rot_reg[CordicSteps][k].x);
            end
        end
    end

    assign out_valid = sc_vld_reg;
    assign out_sc = sc_reg;

    `ASSERT_NEXT(a_hold, clk, rst_n, !adv, vld_reg == $past(vld_reg))
    `ASSERT_NEXT(a_shift, clk, rst_n, adv && in_valid, vld_reg[0])
    `ASSERT_NEXT(a_out, clk, rst_n, adv && vld_reg[CordicSteps], sc_vld_reg)
endmodule
`default_nettype wire

// ----- hdl/e2q_combine.sv -----
// Pair and triple products, sums, rounding and saturation, three register stages.
// Depends on e2q_pkg and assert_macros.svh.
`default_nettype none
module e2q_combine (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic adv,
    input  wire logic in_valid,
    input  e2q_pkg::sc_t in_sc [3],
    output logic out_valid,
    output e2q_pkg::quat_t out_q
);
    import e2q_pkg::*;
    `include "assert_macros.svh"

    // Pair products (Q30) then triple products (Q45).
    logic signed [31:0] p_reg [4];
    trig_t cb_reg, sb_reg;
    logic signed [47:0] t_reg [8];
    quat_t q_reg;
    logic [2:0] vld_reg;
    logic signed [48:0] sum [4];
    logic signed [48:0] rnd [4];
    quat_t q_next;

    function automatic q15_t sat(input logic signed [48:0] v);
        if (v > 49'sd32767)
            return 16'sh7fff;
        else if (v < -49'sd32768)
            return 16'sh8000;
        else
            return v[QW-1:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // 0: h, 1: b, 2: p
            p_reg[0] <= in_sc[0].c * in_sc[2].c;
            p_reg[1] <= in_sc[0].s * in_sc[2].s;
            p_reg[2] <= in_sc[0].c * in_sc[2].s;
            p_reg[3] <= in_sc[0].s * in_sc[2].c;
            cb_reg <= in_sc[1].c;
            sb_reg <= in_sc[1].s;
            t_reg[0] <= p_reg[0] * cb_reg;
            t_reg[1] <= p_reg[1] * sb_reg;
            t_reg[2] <= p_reg[2] * cb_reg;
            t_reg[3] <= p_reg[3] * sb_reg;
            t_reg[4] <= p_reg[3] * cb_reg;
            t_reg[5] <= p_reg[2] * sb_reg;
            t_reg[6] <= p_reg[0] * sb_reg;
            t_reg[7] <= p_reg[1] * cb_reg;
            q_reg <= q_next;
        end
    end

    always_comb
    begin
        sum[0] = 49'(t_reg[0]) + 49'(t_reg[1]);
        sum[1] = 49'(t_reg[2]) + 49'(t_reg[3]);
        sum[2] = 49'(t_reg[4]) - 49'(t_reg[5]);
        sum[3] = 49'(t_reg[6]) - 49'(t_reg[7]);
        for (int k = 0; k < 4; k++)
            rnd[k] = (sum[k] + 49'sd536870912) >>> 30;
        q_next.comp_first = sat(rnd[0]);
        q_next.comp_second = sat(rnd[1]);
        q_next.comp_third = sat(rnd[2]);
        q_next.comp_fourth = sat(rnd[3]);
    end

    assign out_valid = vld_reg[2];
    assign out_q = q_reg;

    `ASSERT_NEXT(a_hold, clk, rst_n, !adv, vld_reg == $past(vld_reg))
    `ASSERT_NEXT(a_in, clk, rst_n, adv && in_valid, vld_reg[0])
    `ASSERT_NEXT(a_mid, clk, rst_n, adv && vld_reg[1], out_valid)
endmodule
`default_nettype wire

// ----- hdl/euler_to_quaternion.sv -----
// Euler angles to quaternion: 16-stage CORDIC, rounding, three product stages.
// Accepts one word per cycle while the pipeline advances.
// The whole pipeline stalls together when the output word is not taken.
// Reset clears all valid bits asynchronously; no word is in flight after it.
`default_nettype none
module euler_to_quaternion (
    input  wire logic clk,
    input  wire logic rst_n,
    e2q_if.sink   in_ch,
    e2q_if.source out_ch
);
    import e2q_pkg::*;
    `include "assert_macros.svh"

    logic adv;
    logic c_valid;
    sc_t c_sc [3];

    // The pipeline moves whenever its last word is empty or being taken.
    assign adv = !out_ch.valid || out_ch.ready;
    assign in_ch.ready = adv;

    e2q_cordic u_cordic (
        .clk(clk), .rst_n(rst_n), .adv(adv),
        .in_valid(in_ch.valid), .in_ang(in_ch.data),
        .out_valid(c_valid), .out_sc(c_sc)
    );

    e2q_combine u_combine (
        .clk(clk), .rst_n(rst_n), .adv(adv),
        .in_valid(c_valid), .in_sc(c_sc),
        .out_valid(out_ch.valid), .out_q(out_ch.data)
    );

    `ASSERT_NEXT(a_stall, clk, rst_n, out_ch.valid && !out_ch.ready, out_ch.valid)
    `ASSERT_IMPL(a_rdy, clk, rst_n, out_ch.valid || in_ch.ready)
    `ASSERT_NEXT(a_keep, clk, rst_n, out_ch.valid && !out_ch.ready, $stable(out_ch.data))
endmodule
`default_nettype wire

// ----- dv/testbench.sv -----
// Self-checking testbench for the Euler angle to quaternion block.
// Depends on e2q_pkg, e2q_if and euler_to_quaternion from the RTL; drives and checks valid/ready words.
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import e2q_pkg::*;

    localparam int Latency = 21;
    localparam int WatchdogLimit = 20000;

    typedef enum int { IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH } idle_mode_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    e2q_if #(.payload_t(angles_t)) in_ch (clk);
    e2q_if #(.payload_t(quat_t)) out_ch (clk);

    euler_to_quaternion uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch),
        .out_ch(out_ch)
    );

    always #1 clk = ~clk;

    angles_t pending_angles[$];
    quat_t expected_quats[$];
    idle_mode_t idle_mode = IDLE_NONE;
    bit hold_output = 1'b0;
    bit finished = 1'b0;
    int failures = 0;
    int words_sent = 0;
    int words_checked = 0;
    int quiet_cycles = 0;

    // Floor division by a power of two on signed values.
    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    // Half-angle sine and cosine in Q15 via fixed-length CORDIC.
    function automatic void half_sin_cos(input ang_t a, output longint s, output longint c);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        longint atan_tab[24];
        atan_tab = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                     10679838, 5340245, 2670163, 1335087, 667544, 333772,
                     166886, 83443, 41722, 20861, 10430, 5215,
                     2608, 1304, 652, 326, 163, 81};
        x = 652032874;
        y = 0;
        z = longint'(a) * 32768;
        for (int i = 0; i < CordicSteps && i < 24; i++)
        begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= atan_tab[i];
            end
            else
            begin
                x += dx;
                y -= dy;
                z += atan_tab[i];
            end
        end
        c = floor_shift(x + 16384, 15);
        s = floor_shift(y + 16384, 15);
    endfunction

    function automatic q15_t saturate_q15(longint sum);
        longint r;
        r = floor_shift(sum + (longint'(1) << 29), 30);
        if (r > 32767)
            r = 32767;
        if (r < -32768)
            r = -32768;
        return q15_t'(r);
    endfunction

    function automatic quat_t predict_quat(angles_t a);
        longint sh, ch, sb, cb, sp, cp;
        quat_t q;
        half_sin_cos(a.heading_angle, sh, ch);
        half_sin_cos(a.bank_angle, sb, cb);
        half_sin_cos(a.pitch_angle, sp, cp);
        q.comp_first = saturate_q15(ch * cp * cb + sh * sp * sb);
        q.comp_second = saturate_q15(ch * sp * cb + sh * cp * sb);
        q.comp_third = saturate_q15(sh * cp * cb - ch * sp * sb);
        q.comp_fourth = saturate_q15(ch * cp * sb - sh * sp * cb);
        return q;
    endfunction

    // Driver: keeps valid high until the word is taken, then pulls the next one unless the idle mode inserts a gap.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.data <= '0;
        end
        else
        begin
            if (!in_ch.valid || in_ch.ready)
            begin
                if (in_ch.valid && in_ch.ready)
                begin
                    expected_quats.push_back(predict_quat(in_ch.data));
                    words_sent++;
                end
                if (pending_angles.size() > 0 &&
                    !((idle_mode == IDLE_SEND && $urandom_range(99) < 85) ||
                      (idle_mode == IDLE_BOTH && $urandom_range(99) < 20)))
                begin
                    in_ch.valid <= 1'b1;
                    in_ch.data <= pending_angles.pop_front();
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // Monitor and receiver stall generation.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_quats.size() == 0)
                begin
                    $error("unexpected output word %h", out_ch.data);
                    failures++;
                end
                else
                begin
                    quat_t e;
                    e = expected_quats.pop_front();
                    if (out_ch.data.comp_first !== e.comp_first)
                    begin
                        $error("comp_first expected %0d actual %0d",
                               e.comp_first, out_ch.data.comp_first);
                        failures++;
                    end
                    if (out_ch.data.comp_second !== e.comp_second)
                    begin
                        $error("comp_second expected %0d actual %0d",
                               e.comp_second, out_ch.data.comp_second);
                        failures++;
                    end
                    if (out_ch.data.comp_third !== e.comp_third)
                    begin
                        $error("comp_third expected %0d actual %0d",
                               e.comp_third, out_ch.data.comp_third);
                        failures++;
                    end
                    if (out_ch.data.comp_fourth !== e.comp_fourth)
                    begin
                        $error("comp_fourth expected %0d actual %0d",
                               e.comp_fourth, out_ch.data.comp_fourth);
                        failures++;
                    end
                    words_checked++;
                end
            end
            if (hold_output)
                out_ch.ready <= 1'b0;
            else if (idle_mode == IDLE_RECV)
                out_ch.ready <= ($urandom_range(99) >= 85);
            else if (idle_mode == IDLE_BOTH)
                out_ch.ready <= ($urandom_range(99) >= 20);
            else
                out_ch.ready <= 1'b1;
        end
    end

    // Watchdog on cycles without any accepted word.
    always @(posedge clk)
    begin
        if (rst_n && !finished)
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WatchdogLimit)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    function automatic ang_t random_angle();
        case ($urandom_range(5))
            0: return ang_t'(16'h8000);
            1: return ang_t'(16'h7fff);
            2: return ang_t'($urandom_range(64) - 32);
            default: return ang_t'($urandom);
        endcase
    endfunction

    task automatic add_angles(ang_t h, ang_t b, ang_t p);
        angles_t a;
        a.heading_angle = h;
        a.bank_angle = b;
        a.pitch_angle = p;
        pending_angles.push_back(a);
    endtask

    task automatic add_random(int count);
        for (int i = 0; i < count; i++)
            add_angles(random_angle(), random_angle(), random_angle());
    endtask

    task automatic drain();
        while (pending_angles.size() > 0 || in_ch.valid || expected_quats.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        ang_t corner[6];
        corner = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'sh4000, 16'shc000, 16'sh0001};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: extremes, quarter turns and the negative half-turn edge.
        for (int i = 0; i < 6; i++)
            add_angles(corner[i], corner[(i + 1) % 6], corner[(i + 3) % 6]);
        add_angles(16'sh8000, 16'sh8000, 16'sh8000);
        add_angles(16'sh7fff, 16'sh7fff, 16'sh7fff);
        add_angles(16'sh0000, 16'sh0000, 16'sh0000);
        add_angles(16'shffff, 16'sh5555, 16'shaaaa);
        add_angles(16'sh2000, 16'sh2000, 16'sh2000);
        add_angles(16'she000, 16'sh6000, 16'sha000);
        drain();

        add_random(120);
        drain();

        // Receiver holds off while the sender keeps offering words.
        hold_output = 1'b1;
        add_random(60);
        repeat (200) @(posedge clk);
        hold_output = 1'b0;
        drain();

        idle_mode = IDLE_SEND;
        add_random(110);
        drain();
        idle_mode = IDLE_RECV;
        add_random(110);
        drain();
        idle_mode = IDLE_BOTH;
        add_random(110);
        drain();
        idle_mode = IDLE_NONE;
        add_random(80);
        drain();

        repeat (Latency + 10) @(posedge clk);
        finished = 1'b1;
        $display("Sent %0d angle words and checked %0d quaternion words across",
                 words_sent, words_checked);
        $display("phases with no idling, sender gaps, receiver stalls and both.");
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
`default_nettype wire
